// ===== hdl/rwft_pkg.sv =====
// Shared types and constants for the recent word frequency table.
// Used by the table top level and its port checker; no dependencies.
package rwft_pkg;

    localparam int TABLE_DEPTH    = 2048;
    localparam int WORD_CHUNKS    = 8;
    localparam int MAX_STORED_LEN = 63;

    localparam int IDX_W    = $clog2(TABLE_DEPTH);
    localparam int FILL_W   = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W    = $clog2(WORD_CHUNKS + 1);
    localparam int WORD_W   = WORD_CHUNKS * 64;
    localparam int WORD_BYTES = WORD_CHUNKS * 8;
    localparam int LEN_MAX  = (WORD_BYTES > MAX_STORED_LEN) ? WORD_BYTES : MAX_STORED_LEN;
    localparam int LEN_W    = $clog2(LEN_MAX + 1);
    localparam int SLOT_W   = 11;
    localparam int COUNT_W  = 32;
    localparam int STAMP_W  = 64;
    localparam int STATUS_W = 3;

    localparam logic CMD_RECORD = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_BUMP    = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_INSERT  = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_REPLACE = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_IGNORED = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_QUERY   = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MASK,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] stamp;
    } row_t;

endpackage

// ===== hdl/recent_word_frequency_table.sv =====
// Recent word frequency table: chunk assembly, entry memory, scan and update.
// Depends on rwft_pkg for sizes, status codes, row layout and state type.
// Flow: a final chunk beat starts the scan that reads one entry row per cycle
// from the entry memory (separate read and write ports); a match ends it early.
// One word at a time: after a final beat the next chunk beat is taken only once
// the result has been loaded into the output register, which a result stall can
// delay. Reset clears control and the fill count; memory content stays undefined.
module recent_word_frequency_table (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic                               cmd,
    input  logic [63:0]                        word_chunk,
    input  logic                               chunk_last,
    input  logic [63:0]                        now_ms,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rwft_pkg::STATUS_W-1:0]      status,
    output logic [rwft_pkg::COUNT_W-1:0]       use_count,
    output logic [rwft_pkg::SLOT_W-1:0]        slot
);

    localparam logic [rwft_pkg::COUNT_W-1:0] COUNT_ONE = rwft_pkg::COUNT_W'(1);

    // entry memory: word, count and time stamp in one row
    rwft_pkg::row_t mem [rwft_pkg::TABLE_DEPTH];
    rwft_pkg::row_t rd_row_reg;
    rwft_pkg::row_t wr_row;
    logic                          rd_en;
    logic                          wr_en;
    logic [rwft_pkg::IDX_W-1:0]    rd_addr;
    logic [rwft_pkg::IDX_W-1:0]    wr_idx;

    rwft_pkg::state_t state_reg, state_next;

    logic [rwft_pkg::POS_W-1:0]    pos_reg, pos_next;
    logic                          found_reg, found_next;
    logic                          overlong_reg, overlong_next;
    logic [rwft_pkg::FILL_W-1:0]   fill_reg, fill_next;
    logic [rwft_pkg::FILL_W-1:0]   issue_reg, issue_next;
    logic                          pend_reg, pend_next;
    logic                          hit_reg, hit_next;
    logic                          min_vld_reg, min_vld_next;
    logic                          out_valid_reg, out_valid_next;

    logic [rwft_pkg::WORD_W-1:0]   word_reg, word_next;
    logic [rwft_pkg::LEN_W-1:0]    len_reg, len_next;
    logic                          cmd_reg, cmd_next;
    logic [rwft_pkg::STAMP_W-1:0]  now_reg, now_next;
    logic                          too_long_reg, too_long_next;
    logic [rwft_pkg::IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [rwft_pkg::IDX_W-1:0]    hit_idx_reg, hit_idx_next;
    logic [rwft_pkg::COUNT_W-1:0]  hit_count_reg, hit_count_next;
    logic [rwft_pkg::STAMP_W-1:0]  min_reg, min_next;
    logic [rwft_pkg::IDX_W-1:0]    min_idx_reg, min_idx_next;
    logic [rwft_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [rwft_pkg::COUNT_W-1:0]  res_count_reg, res_count_next;
    logic [rwft_pkg::SLOT_W-1:0]   res_slot_reg, res_slot_next;
    logic [rwft_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [rwft_pkg::COUNT_W-1:0]  out_count_reg, out_count_next;
    logic [rwft_pkg::SLOT_W-1:0]   out_slot_reg, out_slot_next;

    logic                          beat;
    logic                          issue_more;
    logic                          found_now;
    logic                          scan_end;
    logic                          load_out;
    logic                          zhit;
    logic [2:0]                    zpos;
    logic [rwft_pkg::LEN_W-1:0]    len_eff;
    logic [rwft_pkg::LEN_W-1:0]    cut;
    logic                          long_eff;

    assign beat       = in_valid && !in_stall;
    assign issue_more = issue_reg < fill_reg;
    assign found_now  = pend_reg && !too_long_reg && (rd_row_reg.word == word_reg);
    assign scan_end   = found_now || (!issue_more && !pend_reg);
    assign load_out   = !out_valid_reg || !out_stall;

    // first zero byte of the incoming chunk
    always_comb
    begin
        zhit = 1'b0;
        zpos = 3'd0;
        for (int j = 7; j >= 0; j--)
        begin
            if (word_chunk[j*8 +: 8] == 8'd0)
            begin
                zhit = 1'b1;
                zpos = 3'(j);
            end
        end
    end

    // word length and truncation point once all chunks are in
    always_comb
    begin
        if (found_reg)
        begin
            len_eff = len_reg;
        end
        else if (pos_reg < rwft_pkg::POS_W'(rwft_pkg::WORD_CHUNKS))
        begin
            len_eff = rwft_pkg::LEN_W'({pos_reg, 3'b000});
        end
        else
        begin
            len_eff = rwft_pkg::LEN_W'(rwft_pkg::WORD_BYTES);
        end
        long_eff = (!found_reg && overlong_reg &&
                    pos_reg == rwft_pkg::POS_W'(rwft_pkg::WORD_CHUNKS)) ||
                   (len_eff > rwft_pkg::LEN_W'(rwft_pkg::MAX_STORED_LEN));
        cut = (len_eff > rwft_pkg::LEN_W'(rwft_pkg::MAX_STORED_LEN)) ?
              rwft_pkg::LEN_W'(rwft_pkg::MAX_STORED_LEN) : len_eff;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rwft_pkg::ST_IDLE:
            begin
                if (beat && chunk_last)
                begin
                    state_next = rwft_pkg::ST_MASK;
                end
            end
            rwft_pkg::ST_MASK:
            begin
                state_next = (len_eff == '0) ? rwft_pkg::ST_WRITE : rwft_pkg::ST_SCAN;
            end
            rwft_pkg::ST_SCAN:
            begin
                if (scan_end)
                begin
                    state_next = rwft_pkg::ST_WRITE;
                end
            end
            rwft_pkg::ST_WRITE:
            begin
                state_next = rwft_pkg::ST_DONE;
            end
            rwft_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = rwft_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rwft_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_stall = 1'b1;
        rd_en    = 1'b0;
        unique case (state_reg)
            rwft_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
            end
            rwft_pkg::ST_SCAN:
            begin
                rd_en = issue_more && !found_now;
            end
            rwft_pkg::ST_MASK, rwft_pkg::ST_WRITE, rwft_pkg::ST_DONE:
            begin
                in_stall = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

    assign rd_addr = issue_reg[rwft_pkg::IDX_W-1:0];

    // datapath
    always_comb
    begin
        pos_next        = pos_reg;
        found_next      = found_reg;
        overlong_next   = overlong_reg;
        fill_next       = fill_reg;
        issue_next      = issue_reg;
        pend_next       = 1'b0;
        hit_next        = hit_reg;
        min_vld_next    = min_vld_reg;
        word_next       = word_reg;
        len_next        = len_reg;
        cmd_next        = cmd_reg;
        now_next        = now_reg;
        too_long_next   = too_long_reg;
        pend_idx_next   = pend_idx_reg;
        hit_idx_next    = hit_idx_reg;
        hit_count_next  = hit_count_reg;
        min_next        = min_reg;
        min_idx_next    = min_idx_reg;
        res_status_next = res_status_reg;
        res_count_next  = res_count_reg;
        res_slot_next   = res_slot_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        out_slot_next   = out_slot_reg;
        out_valid_next  = out_valid_reg && out_stall;
        wr_en           = 1'b0;
        wr_idx          = hit_idx_reg;
        wr_row.word     = word_reg;
        wr_row.count    = COUNT_ONE;
        wr_row.stamp    = now_reg;

        case (state_reg)
            rwft_pkg::ST_IDLE:
            begin
                if (beat)
                begin
                    if (pos_reg < rwft_pkg::POS_W'(rwft_pkg::WORD_CHUNKS))
                    begin
                        for (int k = 0; k < rwft_pkg::WORD_CHUNKS; k++)
                        begin
                            if (pos_reg == rwft_pkg::POS_W'(k))
                            begin
                                word_next[k*64 +: 64] = word_chunk;
                            end
                        end
                        pos_next = pos_reg + 1'b1;
                        if (!found_reg && zhit)
                        begin
                            found_next = 1'b1;
                            len_next   = rwft_pkg::LEN_W'({pos_reg, zpos});
                        end
                    end
                    else
                    begin
                        overlong_next = 1'b1;
                    end
                    if (chunk_last)
                    begin
                        cmd_next = cmd;
                        now_next = now_ms;
                    end
                end
            end
            rwft_pkg::ST_MASK:
            begin
                // drop bytes past the word end and past the stored limit
                for (int b = 0; b < rwft_pkg::WORD_BYTES; b++)
                begin
                    if (rwft_pkg::LEN_W'(b) >= cut)
                    begin
                        word_next[b*8 +: 8] = 8'd0;
                    end
                end
                len_next      = len_eff;
                too_long_next = long_eff;
                issue_next    = '0;
                hit_next      = 1'b0;
                min_vld_next  = 1'b0;
            end
            rwft_pkg::ST_SCAN:
            begin
                if (rd_en)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = rd_addr;
                    issue_next    = issue_reg + 1'b1;
                end
                if (found_now)
                begin
                    hit_next       = 1'b1;
                    hit_idx_next   = pend_idx_reg;
                    hit_count_next = rd_row_reg.count;
                end
                else if (pend_reg && (!min_vld_reg || rd_row_reg.stamp < min_reg))
                begin
                    // strict compare keeps the lowest index on a tie
                    min_vld_next = 1'b1;
                    min_next     = rd_row_reg.stamp;
                    min_idx_next = pend_idx_reg;
                end
            end
            rwft_pkg::ST_WRITE:
            begin
                res_count_next = '0;
                res_slot_next  = '0;
                if (cmd_reg == rwft_pkg::CMD_QUERY)
                begin
                    res_status_next = rwft_pkg::STATUS_QUERY;
                    if (hit_reg)
                    begin
                        res_count_next = hit_count_reg;
                        res_slot_next  = rwft_pkg::SLOT_W'(hit_idx_reg);
                    end
                end
                else if (len_reg == '0)
                begin
                    res_status_next = rwft_pkg::STATUS_IGNORED;
                end
                else if (hit_reg)
                begin
                    wr_en        = 1'b1;
                    wr_idx       = hit_idx_reg;
                    wr_row.count = (hit_count_reg == '1) ? hit_count_reg
                                                         : hit_count_reg + 1'b1;
                    res_status_next = rwft_pkg::STATUS_BUMP;
                    res_count_next  = wr_row.count;
                    res_slot_next   = rwft_pkg::SLOT_W'(hit_idx_reg);
                end
                else if (fill_reg < rwft_pkg::FILL_W'(rwft_pkg::TABLE_DEPTH))
                begin
                    wr_en           = 1'b1;
                    wr_idx          = fill_reg[rwft_pkg::IDX_W-1:0];
                    fill_next       = fill_reg + 1'b1;
                    res_status_next = rwft_pkg::STATUS_INSERT;
                    res_count_next  = COUNT_ONE;
                    res_slot_next   = rwft_pkg::SLOT_W'(fill_reg[rwft_pkg::IDX_W-1:0]);
                end
                else
                begin
                    wr_en           = 1'b1;
                    wr_idx          = min_idx_reg;
                    res_status_next = rwft_pkg::STATUS_REPLACE;
                    res_count_next  = COUNT_ONE;
                    res_slot_next   = rwft_pkg::SLOT_W'(min_idx_reg);
                end
                // start the next word from scratch
                pos_next      = '0;
                found_next    = 1'b0;
                overlong_next = 1'b0;
            end
            rwft_pkg::ST_DONE:
            begin
                if (load_out)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_count_next  = res_count_reg;
                    out_slot_next   = res_slot_reg;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_row;
        end
        if (rd_en)
        begin
            rd_row_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rwft_pkg::ST_IDLE;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            overlong_reg  <= 1'b0;
            fill_reg      <= '0;
            issue_reg     <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            min_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            found_reg     <= found_next;
            overlong_reg  <= overlong_next;
            fill_reg      <= fill_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            min_vld_reg   <= min_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg       <= word_next;
        len_reg        <= len_next;
        cmd_reg        <= cmd_next;
        now_reg        <= now_next;
        too_long_reg   <= too_long_next;
        pend_idx_reg   <= pend_idx_next;
        hit_idx_reg    <= hit_idx_next;
        hit_count_reg  <= hit_count_next;
        min_reg        <= min_next;
        min_idx_reg    <= min_idx_next;
        res_status_reg <= res_status_next;
        res_count_reg  <= res_count_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
        out_slot_reg   <= out_slot_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign use_count = out_count_reg;
    assign slot      = out_slot_reg;

endmodule

// ===== hdl/rwft_checker.sv =====
// Port-level checks for the recent word frequency table, bound to the top level.
// Depends on rwft_pkg for status codes and field widths.
module rwft_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_stall,
    input  logic                               chunk_last,
    input  logic                               out_valid,
    input  logic                               out_stall,
    input  logic [rwft_pkg::STATUS_W-1:0]      status,
    input  logic [rwft_pkg::COUNT_W-1:0]       use_count,
    input  logic [rwft_pkg::SLOT_W-1:0]        slot
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) &&
        $stable(use_count) && $stable(slot))
        else $error("result beat changed while stalled");

    // the final chunk of a word blocks further chunks while it is processed
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && chunk_last |=> in_stall)
        else $error("chunk taken while a word is in process");

    a_ignored_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == rwft_pkg::STATUS_IGNORED |->
        use_count == '0 && slot == '0)
        else $error("ignored word reports a count or slot");

    a_new_entry: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == rwft_pkg::STATUS_INSERT ||
                      status == rwft_pkg::STATUS_REPLACE) |->
        use_count == rwft_pkg::COUNT_W'(1))
        else $error("new entry does not start at count one");

    a_bump_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == rwft_pkg::STATUS_BUMP |-> use_count != '0)
        else $error("bumped entry reports zero count");

endmodule

bind recent_word_frequency_table rwft_checker u_rwft_checker (.*);
